// ----- rtl/tof_pkg.sv -----
// Shared types, constants and request codes for the terminal output formatter.
package tof_pkg;

    // Default tab stop spacing and the longest run one character may produce
    localparam int TabStopDefault = 8;
    localparam int MaxRun         = 16;
    localparam int StepW          = $clog2(MaxRun);

    // Character codes
    localparam logic [7:0] ChNul   = 8'h00;
    localparam logic [7:0] ChBel   = 8'h07;
    localparam logic [7:0] ChBs    = 8'h08;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChCrHi  = 8'h8D;
    localparam logic [7:0] ChSub   = 8'h1A;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChCaret = 8'h5E;
    localparam logic [7:0] ChAt    = 8'h40;

    // Configuration register indexes
    localparam logic CfgExpandTabs = 1'b0;
    localparam logic CfgNullCount  = 1'b1;

    // Column unit operations
    typedef enum logic [2:0] {
        COL_HOLD,
        COL_INC,
        COL_DEC,
        COL_CLEAR,
        COL_TABSTOP
    } col_op_t;

    // Character class latched at accept
    typedef enum logic [3:0] {
        K_DROP,
        K_LF,
        K_CR,
        K_TAB_EXP,
        K_TAB_RAW,
        K_BS,
        K_PRINT,
        K_CARET,
        K_RAW
    } kind_t;

    // Request from sequencer to column unit
    typedef struct packed {
        logic    apply;
        col_op_t op;
    } col_cmd_t;

    // Column unit status back to sequencer
    typedef struct packed {
        logic [7:0] col;
        logic [7:0] next_col;
        logic       next_at_stop;
    } col_stat_t;

endpackage

// ----- rtl/tof_col_unit.sv -----
// Column counter with its shared adder and a running remainder modulo the tab stop.
module tof_col_unit import tof_pkg::*; #(
    parameter int TAB_STOP = TabStopDefault
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  col_cmd_t  cmd,
    output col_stat_t stat
);

    localparam int MW = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;
    localparam logic [MW-1:0] ModMax = MW'(TAB_STOP - 1);

    logic [7:0]    col_reg, col_next;
    logic [MW-1:0] mod_reg, mod_next;
    logic [8:0]    addend;
    logic [8:0]    sum;

    // One adder serves the increment, decrement and tab stop updates
    always_comb begin
        case (cmd.op)
            COL_INC:     addend = 9'd1;
            COL_DEC:     addend = 9'h0FF;
            COL_TABSTOP: addend = 9'(TAB_STOP) - 9'(mod_reg);
            default:     addend = 9'd0;
        endcase
        sum = {1'b0, col_reg} + addend;
    end

    // Next column and remainder
    always_comb begin
        col_next = col_reg;
        mod_next = mod_reg;
        unique case (cmd.op)
            COL_HOLD: begin
                col_next = col_reg;
                mod_next = mod_reg;
            end
            COL_INC: begin
                col_next = sum[7:0];
                if (sum[7:0] == 8'd0 || mod_reg == ModMax) mod_next = '0;
                else mod_next = mod_reg + MW'(1);
            end
            COL_DEC: begin
                col_next = sum[7:0];
                mod_next = (mod_reg == '0) ? ModMax : mod_reg - MW'(1);
            end
            COL_CLEAR: begin
                col_next = 8'd0;
                mod_next = '0;
            end
            COL_TABSTOP: begin
                // stop past 255 lands on column 0
                col_next = sum[8] ? 8'd0 : sum[7:0];
                mod_next = '0;
            end
            default: begin
                col_next = col_reg;
                mod_next = mod_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 8'd0;
            mod_reg <= '0;
        end else if (cmd.apply) begin
            col_reg <= col_next;
            mod_reg <= mod_next;
        end
    end

    assign stat.col          = col_reg;
    assign stat.next_col     = col_next;
    assign stat.next_at_stop = (mod_next == '0);

endmodule

// ----- rtl/tof_seq.sv -----
// Sequencer: classifies a character and steps out its byte run through the output register.
module tof_seq import tof_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_char,
    input  logic       s_caret,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_byte,
    output logic [7:0] m_col,
    output logic       m_last,
    input  logic       expand_tabs,
    input  logic [3:0] null_count,
    input  col_stat_t  stat,
    output col_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_in;
    logic [7:0]       char_reg;
    logic [StepW-1:0] step_reg;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_byte_reg;
    logic [7:0]       m_col_reg;
    logic             m_last_reg;

    logic             accept, fire;
    logic [7:0]       run_byte;
    col_op_t          run_op;
    logic             run_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_RUN) && (!m_valid_reg || m_tready);

    // Character classification
    always_comb begin
        if (s_char == ChSub)                       kind_in = K_DROP;
        else if (s_char == ChLf)                   kind_in = K_LF;
        else if (s_char == ChCr || s_char == ChCrHi) kind_in = K_CR;
        else if (s_char == ChTab)                  kind_in = expand_tabs ? K_TAB_EXP : K_TAB_RAW;
        else if (s_char == ChBel)                  kind_in = K_RAW;
        else if (s_char == ChBs)                   kind_in = (stat.col != 8'd0) ? K_BS : K_DROP;
        else if (s_char >= ChSpace)                kind_in = K_PRINT;
        else if (s_caret)                          kind_in = K_CARET;
        else                                       kind_in = K_RAW;
    end

    // Byte and column operation for the current step
    always_comb begin
        run_byte = char_reg;
        run_op   = COL_HOLD;
        case (kind_reg)
            K_LF: begin
                run_byte = (step_reg == '0) ? ChLf : ChNul;
                run_op   = (step_reg == '0) ? COL_CLEAR : COL_HOLD;
            end
            K_CR: begin
                run_byte = ChCr;
                run_op   = COL_CLEAR;
            end
            K_TAB_EXP: begin
                run_byte = ChSpace;
                run_op   = COL_INC;
            end
            K_TAB_RAW: begin
                run_byte = ChTab;
                run_op   = COL_TABSTOP;
            end
            K_BS: begin
                run_byte = ChBs;
                run_op   = COL_DEC;
            end
            K_PRINT: begin
                run_op   = COL_INC;
            end
            K_CARET: begin
                run_byte = (step_reg == '0) ? ChCaret : char_reg + ChAt;
                run_op   = COL_INC;
            end
            default: begin
                run_byte = char_reg;
                run_op   = COL_HOLD;
            end
        endcase
    end

    // End of run for the current step
    always_comb begin
        case (kind_reg)
            K_LF:      run_last = (step_reg == null_count);
            K_TAB_EXP: run_last = stat.next_at_stop || (step_reg == StepW'(MaxRun - 1));
            K_CARET:   run_last = (step_reg != '0);
            default:   run_last = 1'b1;
        endcase
    end

    assign cmd.apply = fire;
    assign cmd.op    = run_op;

    // State sequencing
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && kind_in != K_DROP) state_next = ST_RUN;
            ST_RUN:  if (fire && run_last) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (accept) step_reg <= '0;
            else if (fire) step_reg <= step_reg + StepW'(1);
        end
    end

    // Item and output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= kind_in;
            char_reg <= s_char;
        end
        if (fire) begin
            m_byte_reg <= run_byte;
            m_col_reg  <= stat.next_col;
            m_last_reg <= run_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_byte   = m_byte_reg;
    assign m_col    = m_col_reg;
    assign m_last   = m_last_reg;

endmodule

// ----- rtl/terminal_output_formatter.sv -----
// Top level of the terminal output formatter: config registers, sequencer and column unit.
//
// Input stream: one character per request, s_tdata = char_byte, s_tuser = caret_controls.
// Output stream: one terminal byte per request, m_tdata = {column_now, out_byte},
// m_tlast marks the final byte produced by an input character.
// Configuration: cfg_wr_en with cfg_index 0 writes expand_tabs (bit 0), index 1 writes
// null_count (bits 3:0); write only while the block is idle.
// Rate: a character is taken only while no run is being produced. Its bytes are loaded one
// per cycle into a single output register, pausing while that register holds a byte that
// m_tready has not taken, and the next character can be taken on the cycle after the last
// load. The worst case (LF with 15 pads, or a tab expansion with a tab stop of 16 or
// more) is 16 bytes. SUB, and BS at column 0, give no bytes and the block is ready
// again on the next cycle. The shared column adder does one update per emitted byte.
// Stall: while m_tready is low the output register holds and the run pauses; the next
// character may be accepted while the final byte still waits.
// Reset: aresetn (synchronous, active low) clears the column, both config registers and
// any run in progress.
module terminal_output_formatter import tof_pkg::*; #(
    parameter int TAB_STOP = TabStopDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tuser,   // [0] caret_controls
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] column_now
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wdata
);

    logic       expand_tabs_reg;
    logic [3:0] null_count_reg;
    col_cmd_t   cmd;
    col_stat_t  stat;
    logic [7:0] out_byte;
    logic [7:0] column_now;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expand_tabs_reg <= 1'b0;
            null_count_reg  <= 4'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CfgExpandTabs: expand_tabs_reg <= cfg_wdata[0];
                CfgNullCount:  null_count_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tof_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_char      (s_tdata),
        .s_caret     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_byte      (out_byte),
        .m_col       (column_now),
        .m_last      (m_tlast),
        .expand_tabs (expand_tabs_reg),
        .null_count  (null_count_reg),
        .stat        (stat),
        .cmd         (cmd)
    );

    tof_col_unit #(
        .TAB_STOP (TAB_STOP)
    ) u_col (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

    assign m_tdata = {column_now, out_byte};

endmodule

// ----- rtl/tof_checker.sv -----
// Port-level checks for the terminal output formatter, bound to the top level.
module tof_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // A run in progress blocks new characters
    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready while a run is still being produced");

    // SUB yields nothing, so the block is ready straight away
    a_sub_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata == 8'h1A |=> s_tready)
        else $error("SUB did not leave the block idle");

    // LF always starts a run
    a_lf_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata == 8'h0A |=> !s_tready)
        else $error("LF accepted but no run started");

    // Line feed and carriage return report column zero
    a_eol_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[7:0] == 8'h0A || m_tdata[7:0] == 8'h0D) |-> m_tdata[15:8] == 8'd0)
        else $error("end of line byte with nonzero column");

    // A stalled byte holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed under stall");

endmodule

bind terminal_output_formatter tof_checker u_tof_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
